FILE: rtl/assert_macros.svh
// Assertion helpers for the checker file.
// Every macro expects signals named clk and rst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CHK_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define CHK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: rtl/trie_km_pkg.sv
package trie_km_pkg;

    // Result status codes
    localparam logic [1:0] ST_WRITE_DONE  = 2'd0;
    localparam logic [1:0] ST_MATCHING    = 2'd1;
    localparam logic [1:0] ST_TOKEN_MATCH = 2'd2;
    localparam logic [1:0] ST_NO_MATCH    = 2'd3;

    // Input action codes
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_CHAR  = 1'b1;

    // Table byte fields
    localparam logic [7:0] CHAR_MASK   = 8'h7f;
    localparam logic [7:0] LAST_OPTION = 8'h80;

    // Fixed field widths
    localparam int POS_W   = 10;
    localparam int TOKEN_W = 7;

    // Commands from the controller to the datapath
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_ACCEPT_WRITE,
        CMD_ACCEPT_STICKY,
        CMD_ACCEPT_SCAN,
        CMD_READ_CB,
        CMD_READ_OFF,
        CMD_TERMINAL,
        CMD_JUMP,
        CMD_FAIL,
        CMD_NEXT_PAIR,
        CMD_WRAP,
        CMD_READ_TK,
        CMD_READ_TK_OFF,
        CMD_FINISH
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic failed;
        logic off_zero;
        logic char_hit;
        logic last_opt;
        logic pair_last;
        logic wrap_done;
    } dp_status_t;

endpackage

FILE: rtl/trie_keyword_matcher_top.sv
// Channel   Transfer condition       Signals
// -------   ----------------------   ------------------------------------------------
// command   start && !busy at edge   action, table_address, table_byte,
//                                    character, first_of_token
// result    done (one cycle)         status, token_index, position
//
// A table write's result shows the next cycle and a new command may be
// issued at once. A character whose token already failed finishes the same
// way. Any other character reads the option pairs one by one (code byte, then
// offset byte, then evaluate) and, after a branch, waits out any table wrap of
// the jump target and reads the target pair; the single read port of the
// table memory sets this pace. busy is high while a scan runs.
// Reset clears the walk position, the no-match flag and the controller; the
// table contents are undefined until written. The result side cannot stall.
module trie_keyword_matcher_top #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic       action,
    input  logic [9:0] table_address,
    input  logic [7:0] table_byte,
    input  logic [7:0] character,
    input  logic       first_of_token,
    output logic       done,
    output logic [1:0] status,
    output logic [6:0] token_index,
    output logic [9:0] position
);

    // Command and status between sequencer and datapath
    trie_km_pkg::cmd_t       cmd;
    trie_km_pkg::dp_status_t dp_status;

    // Sequence each transfer: write, sticky fail, or pair-by-pair scan.
    trie_km_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .action         (action),
        .first_of_token (first_of_token),
        .dp_status      (dp_status),
        .cmd            (cmd),
        .busy           (busy)
    );

    // Hold the table, the walk state and the result registers.
    trie_km_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .table_address  (table_address),
        .table_byte     (table_byte),
        .character      (character),
        .first_of_token (first_of_token),
        .dp_status      (dp_status),
        .done           (done),
        .status         (status),
        .token_index    (token_index),
        .position       (position)
    );

endmodule

FILE: rtl/trie_km_ctrl.sv
module trie_km_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic                    action,
    input  logic                    first_of_token,
    input  trie_km_pkg::dp_status_t dp_status,
    output trie_km_pkg::cmd_t       cmd,
    output logic                    busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_CB,
        S_RD_OFF,
        S_EVAL,
        S_WRAP,
        S_TK_B,
        S_TK_EVAL
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = trie_km_pkg::CMD_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (action == trie_km_pkg::ACT_WRITE)
                    begin
                        cmd = trie_km_pkg::CMD_ACCEPT_WRITE;
                    end
                    else if (!first_of_token && dp_status.failed)
                    begin
                        cmd = trie_km_pkg::CMD_ACCEPT_STICKY;
                    end
                    else
                    begin
                        cmd        = trie_km_pkg::CMD_ACCEPT_SCAN;
                        state_next = S_RD_CB;
                    end
                end
            end
            S_RD_CB:
            begin
                cmd        = trie_km_pkg::CMD_READ_CB;
                state_next = S_RD_OFF;
            end
            S_RD_OFF:
            begin
                cmd        = trie_km_pkg::CMD_READ_OFF;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (dp_status.off_zero)
                begin
                    cmd        = trie_km_pkg::CMD_TERMINAL;
                    state_next = S_IDLE;
                end
                else if (dp_status.char_hit)
                begin
                    cmd        = trie_km_pkg::CMD_JUMP;
                    state_next = S_WRAP;
                end
                else if (dp_status.last_opt || dp_status.pair_last)
                begin
                    cmd        = trie_km_pkg::CMD_FAIL;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd        = trie_km_pkg::CMD_NEXT_PAIR;
                    state_next = S_RD_CB;
                end
            end
            S_WRAP:
            begin
                if (dp_status.wrap_done)
                begin
                    cmd        = trie_km_pkg::CMD_READ_TK;
                    state_next = S_TK_B;
                end
                else
                begin
                    cmd = trie_km_pkg::CMD_WRAP;
                end
            end
            S_TK_B:
            begin
                cmd        = trie_km_pkg::CMD_READ_TK_OFF;
                state_next = S_TK_EVAL;
            end
            S_TK_EVAL:
            begin
                cmd        = trie_km_pkg::CMD_FINISH;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/trie_km_datapath.sv
module trie_km_datapath #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  trie_km_pkg::cmd_t       cmd,
    input  logic [9:0]              table_address,
    input  logic [7:0]              table_byte,
    input  logic [7:0]              character,
    input  logic                    first_of_token,
    output trie_km_pkg::dp_status_t dp_status,
    output logic                    done,
    output logic [1:0]              status,
    output logic [6:0]              token_index,
    output logic [9:0]              position
);

    localparam int AW      = $clog2(TABLE_DEPTH);
    localparam int PW      = (AW > trie_km_pkg::POS_W) ? AW : trie_km_pkg::POS_W;
    localparam int SW      = AW + 9;
    localparam int CW      = $clog2(TABLE_DEPTH / 2);
    localparam logic [CW-1:0] PAIR_LAST = CW'(TABLE_DEPTH / 2 - 1);
    localparam logic [AW:0]   DEPTH_A   = (AW + 1)'(TABLE_DEPTH);
    localparam logic [SW-1:0] DEPTH_S   = SW'(TABLE_DEPTH);

    logic [7:0]    mem [TABLE_DEPTH];
    logic [7:0]    rd_data_reg;
    logic [AW-1:0] rd_addr;

    logic [AW-1:0] walk_reg;
    logic          failed_reg;
    logic [AW-1:0] scan_pos_reg;
    logic [CW-1:0] pair_cnt_reg;
    logic [7:0]    ch_reg;
    logic [7:0]    cb_reg;
    logic [SW-1:0] sum_reg;

    logic          done_reg;
    logic [1:0]    status_reg;
    logic [6:0]    token_reg;
    logic [AW-1:0] pos_out_reg;

    logic [PW-1:0] wr_addr_wide;
    logic          wr_in_range;
    logic [PW-1:0] pos_wide;

    // Add a small step and wrap once around the table.
    function automatic logic [AW-1:0] step_wrap(input logic [AW-1:0] p,
                                                input logic [1:0] k);
        logic [AW:0] s;
        s = {1'b0, p} + (AW + 1)'(k);
        if (s >= DEPTH_A)
        begin
            s = s - DEPTH_A;
        end
        return s[AW-1:0];
    endfunction

    assign wr_addr_wide = PW'(table_address);
    assign wr_in_range  = (32'(table_address) < 32'(TABLE_DEPTH));

    always_comb
    begin
        case (cmd)
            trie_km_pkg::CMD_READ_CB:     rd_addr = scan_pos_reg;
            trie_km_pkg::CMD_READ_OFF:    rd_addr = step_wrap(scan_pos_reg, 2'd1);
            trie_km_pkg::CMD_READ_TK:     rd_addr = sum_reg[AW-1:0];
            trie_km_pkg::CMD_READ_TK_OFF: rd_addr = step_wrap(sum_reg[AW-1:0], 2'd1);
            default:                      rd_addr = scan_pos_reg;
        endcase
    end

    // Table store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd == trie_km_pkg::CMD_ACCEPT_WRITE && wr_in_range)
        begin
            mem[wr_addr_wide[AW-1:0]] <= table_byte;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign dp_status.failed    = failed_reg;
    assign dp_status.off_zero  = (rd_data_reg == 8'd0);
    assign dp_status.char_hit  = ({1'b0, cb_reg[6:0]} == ch_reg);
    assign dp_status.last_opt  = ((cb_reg & trie_km_pkg::LAST_OPTION) != 8'd0);
    assign dp_status.pair_last = (pair_cnt_reg == PAIR_LAST);
    assign dp_status.wrap_done = (sum_reg < DEPTH_S);

    // Walk state, fail flag and done flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_reg   <= '0;
            failed_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= (cmd == trie_km_pkg::CMD_ACCEPT_WRITE)
                     || (cmd == trie_km_pkg::CMD_ACCEPT_STICKY)
                     || (cmd == trie_km_pkg::CMD_TERMINAL)
                     || (cmd == trie_km_pkg::CMD_FAIL)
                     || (cmd == trie_km_pkg::CMD_FINISH);
            case (cmd)
                trie_km_pkg::CMD_ACCEPT_SCAN:
                begin
                    if (first_of_token)
                    begin
                        walk_reg   <= '0;
                        failed_reg <= 1'b0;
                    end
                end
                trie_km_pkg::CMD_TERMINAL:
                begin
                    walk_reg <= scan_pos_reg;
                end
                trie_km_pkg::CMD_FAIL:
                begin
                    failed_reg <= 1'b1;
                end
                trie_km_pkg::CMD_FINISH:
                begin
                    walk_reg <= sum_reg[AW-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // Scan payload and result registers
    always_ff @(posedge clk)
    begin
        case (cmd)
            trie_km_pkg::CMD_ACCEPT_WRITE:
            begin
                status_reg  <= trie_km_pkg::ST_WRITE_DONE;
                token_reg   <= '0;
                pos_out_reg <= walk_reg;
            end
            trie_km_pkg::CMD_ACCEPT_STICKY:
            begin
                status_reg  <= trie_km_pkg::ST_NO_MATCH;
                token_reg   <= '0;
                pos_out_reg <= walk_reg;
            end
            trie_km_pkg::CMD_ACCEPT_SCAN:
            begin
                ch_reg       <= character;
                pair_cnt_reg <= '0;
                scan_pos_reg <= first_of_token ? '0 : walk_reg;
            end
            trie_km_pkg::CMD_READ_OFF:
            begin
                cb_reg <= rd_data_reg;
            end
            trie_km_pkg::CMD_TERMINAL:
            begin
                status_reg  <= trie_km_pkg::ST_TOKEN_MATCH;
                token_reg   <= cb_reg[6:0];
                pos_out_reg <= scan_pos_reg;
            end
            trie_km_pkg::CMD_JUMP:
            begin
                sum_reg <= SW'(scan_pos_reg) + SW'({rd_data_reg, 1'b0});
            end
            trie_km_pkg::CMD_FAIL:
            begin
                status_reg  <= trie_km_pkg::ST_NO_MATCH;
                token_reg   <= '0;
                pos_out_reg <= walk_reg;
            end
            trie_km_pkg::CMD_NEXT_PAIR:
            begin
                scan_pos_reg <= step_wrap(scan_pos_reg, 2'd2);
                pair_cnt_reg <= pair_cnt_reg + 1'b1;
            end
            trie_km_pkg::CMD_WRAP:
            begin
                sum_reg <= sum_reg - DEPTH_S;
            end
            trie_km_pkg::CMD_READ_TK_OFF:
            begin
                cb_reg <= rd_data_reg;
            end
            trie_km_pkg::CMD_FINISH:
            begin
                pos_out_reg <= sum_reg[AW-1:0];
                if (rd_data_reg == 8'd0)
                begin
                    status_reg <= trie_km_pkg::ST_TOKEN_MATCH;
                    token_reg  <= cb_reg[6:0];
                end
                else
                begin
                    status_reg <= trie_km_pkg::ST_MATCHING;
                    token_reg  <= '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign pos_wide    = PW'(pos_out_reg);
    assign done        = done_reg;
    assign status      = status_reg;
    assign token_index = token_reg;
    assign position    = pos_wide[trie_km_pkg::POS_W-1:0];

endmodule

FILE: rtl/trie_km_checker.sv
`include "assert_macros.svh"

module trie_km_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       action,
    input logic       done,
    input logic [1:0] status,
    input logic [6:0] token_index
);

    // A write reports completion in the very next cycle.
    `CHK_NEXT(a_write_result, start && !busy && (action == trie_km_pkg::ACT_WRITE), done && (status == trie_km_pkg::ST_WRITE_DONE))

    // Each transfer either finishes next cycle or keeps the block busy.
    `CHK_NEXT(a_accept_progress, start && !busy, done || busy)

    // Results only appear once the sequencer is back to idle.
    `CHK_SAME(a_done_idle, done, !busy)

    // Token index is zero unless a token matched.
    `CHK_SAME(a_token_zero, done && (status != trie_km_pkg::ST_TOKEN_MATCH), token_index == 7'd0)

endmodule

bind trie_keyword_matcher_top trie_km_checker u_trie_km_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .action      (action),
    .done        (done),
    .status      (status),
    .token_index (token_index)
);
